[src/pcr_pkg.sv]
// Shared types and constants for the panel controller register block.
// No dependencies; used by pcr_dim_timer, pcr_core and the top level.
package pcr_pkg;

    // Transaction kinds on the item channel
    localparam logic [2:0] FUNC_BUS_READ  = 3'd0;
    localparam logic [2:0] FUNC_BUS_WRITE = 3'd1;
    localparam logic [2:0] FUNC_KBD_READ  = 3'd2;
    localparam logic [2:0] FUNC_TICK      = 3'd3;
    localparam logic [2:0] FUNC_VS_START  = 3'd4;
    localparam logic [2:0] FUNC_VS_END    = 3'd5;

    // Port offsets in the window
    localparam logic [2:0] OFFSET_INDEX = 3'd0;
    localparam logic [2:0] OFFSET_DATA  = 3'd1;

    // Control register indexes
    localparam logic [7:0] CREG_FRAME = 8'd0;
    localparam logic [7:0] CREG_PANEL = 8'd1;
    localparam logic [7:0] CREG_DIM   = 8'd2;

    // Read-back constants
    localparam logic [7:0] RD_EMPTY      = 8'hFF;
    localparam logic [7:0] RD_EXT_NIBBLE = 8'h0F;
    localparam logic [7:0] RD_VSYNC      = 8'h50;
    localparam logic [7:0] RD_LEAD       = 8'h10;
    localparam logic [7:0] RD_ACTIVE     = 8'hB0;
    localparam logic [7:0] RD_HIGH_MASK  = 8'hF0;

    // Register 1 bit positions
    localparam int PANEL_EXT_BIT    = 6;
    localparam int PANEL_DIM_N_BIT  = 7;
    localparam int DIM_PROG_BIT     = 7;

    // Configuration register
    localparam logic [15:0] TPM_RESET = 16'd60;
    localparam int          PADDR_W   = 3;
    localparam int          PDATA_W   = 32;
    localparam logic        CFG_TPM   = 1'b0;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] port_offset;
        logic [7:0] write_data;
        logic [3:0] panel_level;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       panel_disabled;
        logic       panel_asleep;
        logic       external_display;
    } result_t;

    // Control from the register core to the auto-dim timer
    typedef struct packed {
        logic       step;
        logic       restart;
        logic       clear_trip;
        logic       tick;
        logic       running;
        logic [6:0] dim_minutes;
    } dim_ctrl_t;

endpackage

[src/pcr_dim_timer.sv]
// Auto-dim timer: sub-minute and minute counters plus the trip flag.
// Depends on pcr_pkg (dim_ctrl_t).
module pcr_dim_timer
(
    input  logic              clk,
    input  logic              rst_n,
    input  pcr_pkg::dim_ctrl_t ctrl,
    input  logic [15:0]       ticks_per_minute,
    output logic              tripped,
    output logic              tripped_next
);

    logic [15:0] sub_reg;
    logic [15:0] sub_next;
    logic [6:0]  min_reg;
    logic [6:0]  min_next;
    logic        trip_reg;
    logic        trip_next;
    logic [15:0] limit;
    logic [15:0] sub_inc;
    logic [6:0]  min_inc;

    // zero ticks per minute behaves as one
    assign limit   = (ticks_per_minute == 16'd0) ? 16'd1 : ticks_per_minute;
    assign sub_inc = sub_reg + 16'd1;
    assign min_inc = min_reg + 7'd1;

    always_comb
    begin
        sub_next  = sub_reg;
        min_next  = min_reg;
        trip_next = trip_reg;
        if (ctrl.step)
        begin
            if (ctrl.restart)
            begin
                sub_next = '0;
                min_next = '0;
            end
            if (ctrl.clear_trip)
            begin
                trip_next = 1'b0;
            end
            if (ctrl.tick && ctrl.running)
            begin
                if (sub_inc >= limit)
                begin
                    sub_next = '0;
                    if (min_inc >= ctrl.dim_minutes)
                    begin
                        min_next  = '0;
                        trip_next = 1'b1;
                    end
                    else
                    begin
                        min_next = min_inc;
                    end
                end
                else
                begin
                    sub_next = sub_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg  <= '0;
            min_reg  <= '0;
            trip_reg <= 1'b0;
        end
        else
        begin
            sub_reg  <= sub_next;
            min_reg  <= min_next;
            trip_reg <= trip_next;
        end
    end

    assign tripped      = trip_reg;
    assign tripped_next = trip_next;

endmodule

[src/pcr_core.sv]
// Register core: index/data port decode, control registers, vsync phase
// tracking and panel status. Depends on pcr_pkg and pcr_dim_timer.
module pcr_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  pcr_pkg::item_t     item,
    input  logic [15:0]        ticks_per_minute,
    output pcr_pkg::result_t   result
);

    logic [7:0] index_reg;
    logic [7:0] index_next;
    logic [7:0] creg0_reg;
    logic [7:0] creg0_next;
    logic [7:0] creg1_reg;
    logic [7:0] creg1_next;
    logic [7:0] creg2_reg;
    logic [7:0] creg2_next;
    logic [6:0] dim_min_reg;
    logic [6:0] dim_min_next;
    logic       vsync_reg;
    logic       vsync_next;
    logic       lead_reg;
    logic       lead_next;
    logic [3:0] level_reg;
    logic [3:0] level_next;

    logic                tripped;
    logic                tripped_next;
    pcr_pkg::dim_ctrl_t  dim_ctrl;
    logic                phase_shown;
    logic                disabled_now;
    logic                disabled_next;
    logic [7:0]          rd;
    logic [7:0]          panel_rd;
    logic                lead_clear;

    assign phase_shown  = creg0_reg[0];
    assign disabled_now = creg1_reg[pcr_pkg::PANEL_EXT_BIT]
                        | (tripped & ~creg1_reg[pcr_pkg::PANEL_DIM_N_BIT]);

    // register 1 read-back, with the phase bits when creg0 bit 0 is set
    always_comb
    begin
        panel_rd   = (creg1_reg[pcr_pkg::PANEL_EXT_BIT] ? pcr_pkg::RD_EXT_NIBBLE : 8'h00)
                   | {4'h0, level_reg};
        lead_clear = 1'b0;
        if (phase_shown)
        begin
            if (vsync_reg)
            begin
                panel_rd = panel_rd | pcr_pkg::RD_VSYNC;
            end
            else if (lead_reg)
            begin
                panel_rd   = panel_rd | pcr_pkg::RD_LEAD;
                lead_clear = 1'b1;
            end
            else
            begin
                panel_rd = panel_rd | pcr_pkg::RD_ACTIVE;
            end
        end
        else
        begin
            panel_rd = panel_rd | (creg1_reg & pcr_pkg::RD_HIGH_MASK);
        end
    end

    always_comb
    begin
        index_next   = index_reg;
        creg0_next   = creg0_reg;
        creg1_next   = creg1_reg;
        creg2_next   = creg2_reg;
        dim_min_next = dim_min_reg;
        vsync_next   = vsync_reg;
        lead_next    = lead_reg;
        level_next   = level_reg;
        rd           = pcr_pkg::RD_EMPTY;
        dim_ctrl.step        = step;
        dim_ctrl.restart     = 1'b0;
        dim_ctrl.clear_trip  = 1'b0;
        dim_ctrl.tick        = 1'b0;
        dim_ctrl.running     = ~creg1_reg[pcr_pkg::PANEL_DIM_N_BIT] & (dim_min_reg != 7'd0);
        dim_ctrl.dim_minutes = dim_min_reg;

        case (item.func)
            pcr_pkg::FUNC_BUS_READ:
            begin
                if (item.port_offset == pcr_pkg::OFFSET_DATA)
                begin
                    case (index_reg)
                        pcr_pkg::CREG_FRAME: rd = creg0_reg;
                        pcr_pkg::CREG_PANEL:
                        begin
                            rd = panel_rd;
                            if (lead_clear)
                            begin
                                lead_next = 1'b0;
                            end
                        end
                        pcr_pkg::CREG_DIM:   rd = creg2_reg;
                        default:             rd = pcr_pkg::RD_EMPTY;
                    endcase
                end
            end
            pcr_pkg::FUNC_BUS_WRITE:
            begin
                if (item.port_offset == pcr_pkg::OFFSET_INDEX)
                begin
                    index_next = item.write_data;
                end
                else if (item.port_offset == pcr_pkg::OFFSET_DATA)
                begin
                    case (index_reg)
                        pcr_pkg::CREG_FRAME: creg0_next = item.write_data;
                        pcr_pkg::CREG_PANEL:
                        begin
                            creg1_next       = item.write_data;
                            dim_ctrl.restart = 1'b1;
                        end
                        pcr_pkg::CREG_DIM:
                        begin
                            creg2_next       = item.write_data;
                            dim_min_next     = item.write_data[pcr_pkg::DIM_PROG_BIT]
                                             ? item.write_data[6:0] : 7'd0;
                            dim_ctrl.restart = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pcr_pkg::FUNC_KBD_READ:
            begin
                dim_ctrl.restart    = 1'b1;
                dim_ctrl.clear_trip = 1'b1;
            end
            pcr_pkg::FUNC_TICK:
            begin
                dim_ctrl.tick = 1'b1;
            end
            pcr_pkg::FUNC_VS_START:
            begin
                vsync_next = 1'b1;
                lead_next  = 1'b0;
                level_next = disabled_now ? 4'h0 : item.panel_level;
            end
            pcr_pkg::FUNC_VS_END:
            begin
                vsync_next = 1'b0;
                lead_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    pcr_dim_timer u_dim_timer
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (dim_ctrl),
        .ticks_per_minute (ticks_per_minute),
        .tripped          (tripped),
        .tripped_next     (tripped_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            creg0_reg   <= '0;
            creg1_reg   <= '0;
            creg2_reg   <= '0;
            dim_min_reg <= '0;
            vsync_reg   <= 1'b0;
            lead_reg    <= 1'b0;
            level_reg   <= '0;
        end
        else if (step)
        begin
            index_reg   <= index_next;
            creg0_reg   <= creg0_next;
            creg1_reg   <= creg1_next;
            creg2_reg   <= creg2_next;
            dim_min_reg <= dim_min_next;
            vsync_reg   <= vsync_next;
            lead_reg    <= lead_next;
            level_reg   <= level_next;
        end
    end

    // status reflects the state after this transaction
    assign disabled_next = creg1_next[pcr_pkg::PANEL_EXT_BIT]
                         | (tripped_next & ~creg1_next[pcr_pkg::PANEL_DIM_N_BIT]);

    assign result.read_data        = rd;
    assign result.panel_disabled   = disabled_next;
    assign result.panel_asleep     = disabled_next & ~creg1_next[pcr_pkg::PANEL_EXT_BIT];
    assign result.external_display = creg1_next[pcr_pkg::PANEL_EXT_BIT];

endmodule

[src/panel_controller_registers_top.sv]
// Top level of the panel controller register block: input register, result
// register and APB configuration port. Depends on pcr_pkg and pcr_core.
//
//  Channel   Handshake             Payload
//  --------  --------------------  ------------------------------------------
//  item in   in_valid / in_ready   func, port_offset, write_data, panel_level
//  result    out_valid / out_ready read_data, panel_disabled, panel_asleep,
//                                  external_display
//  config    APB (psel/penable)    paddr, pwdata, prdata; pready tied high
//
// One transaction per cycle sustained while out_ready stays high. Each is
// captured in the input register at the accepting edge, then decoded and
// committed to the block state once the result register is free or being
// emptied; that edge also loads the output register and raises out_valid.
// The input register takes one more transaction while a result waits; with
// both stages full in_ready drops until out_ready. Reset (rst_n, asynchronous)
// clears all but the item and result payloads; ticks_per_minute returns to 60.
module panel_controller_registers_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   func,
    input  logic [2:0]                   port_offset,
    input  logic [7:0]                   write_data,
    input  logic [3:0]                   panel_level,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   read_data,
    output logic                         panel_disabled,
    output logic                         panel_asleep,
    output logic                         external_display,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcr_pkg::PADDR_W-1:0]  paddr,
    input  logic [pcr_pkg::PDATA_W-1:0]  pwdata,
    output logic [pcr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // configuration register
    logic [15:0] tpm_reg;
    logic        cfg_write;
    logic        cfg_hit;

    // input stage
    logic             s1_valid_reg;
    pcr_pkg::item_t   s1_item_reg;
    logic             advance;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    pcr_pkg::result_t  out_result_reg;
    pcr_pkg::result_t  core_result;

    assign pready    = 1'b1;
    // register index is the word address
    assign cfg_hit   = (paddr[2] == pcr_pkg::CFG_TPM);
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = cfg_hit ? {16'h0000, tpm_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg <= pcr_pkg::TPM_RESET;
        end
        else if (cfg_write && cfg_hit)
        begin
            tpm_reg <= pwdata[15:0];
        end
    end

    // stage 1 moves on when the result register is free or being emptied
    assign advance  = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.func        <= func;
            s1_item_reg.port_offset <= port_offset;
            s1_item_reg.write_data  <= write_data;
            s1_item_reg.panel_level <= panel_level;
        end
    end

    pcr_core u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .item             (s1_item_reg),
        .ticks_per_minute (tpm_reg),
        .result           (core_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = out_result_reg.read_data;
    assign panel_disabled   = out_result_reg.panel_disabled;
    assign panel_asleep     = out_result_reg.panel_asleep;
    assign external_display = out_result_reg.external_display;

endmodule
